/* hw/rtl/imh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_pkg
// shared sizes, command and status codes for the indexed min-heap
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_BITS = 32;
  localparam int DEPTH    = CAPACITY + 1;
  localparam int ID_W     = $clog2(DEPTH);
  localparam int POS_W    = ID_W + 1;

  typedef logic [ID_W-1:0]     id_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [KEY_BITS-1:0] key_t;

  typedef enum logic [2:0] {
    CMD_LOAD     = 3'd0,
    CMD_BUILD    = 3'd1,
    CMD_EXTRACT  = 3'd2,
    CMD_DECREASE = 3'd3,
    CMD_QUERY    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_LARGER = 2'd2,
    ST_BAD    = 2'd3
  } status_t;

endpackage

/* hw/rtl/imh_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_req_if / imh_rsp_if
// valid/ready channels carrying heap commands and their results
// ----------------------------------------------------------------------------
interface imh_req_if;
  logic                   valid;
  logic                   ready;
  logic [2:0]             command;
  imh_pkg::id_t           element_id;
  imh_pkg::key_t          key_value;
  modport source (output valid, command, element_id, key_value, input ready);
  modport sink   (input valid, command, element_id, key_value, output ready);
endinterface

interface imh_rsp_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  imh_pkg::id_t           result_id;
  imh_pkg::key_t          result_key;
  imh_pkg::id_t           result_position;
  imh_pkg::id_t           live_count;
  modport source (output valid, status, result_id, result_key, result_position,
                  live_count, input ready);
  modport sink   (input valid, status, result_id, result_key, result_position,
                  live_count, output ready);
endinterface

/* hw/rtl/imh_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/indexed_min_heap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap
// indexed binary min-heap with position map and decrease-key
// ----------------------------------------------------------------------------
// usage
//   req channel: command, element_id, key_value; taken only while the
//   sequencer is idle. rsp channel: one result per command, held in an
//   output register until the receiver takes the transfer; the next command
//   may be taken while that result still waits.
//   load, query, bad id, empty extract and unused commands walk no heap
//   levels; extract grows with each heap level walked down, decrease with
//   each level walked up, and build with the sift down of each inner node.
//   a sift over 256 entries walks at most 8 levels.
//   the rate is set by the single read port of each of the three rams
//   (slots, keys, positions): each heap level costs dependent ram reads.
//   reset: synchronous, clears the heap and load counts and the handshakes;
//   ram contents are only read once written, so no clearing pass is needed.
//   a stalled receiver holds the result register; a finished command then
//   waits in the response state until the register is free.
// ----------------------------------------------------------------------------
module indexed_min_heap (
  input  logic   clk,
  input  logic   rst,
  imh_req_if.sink   req,
  imh_rsp_if.source rsp
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_DISP   = 16'h0002,
    S_X_M    = 16'h0004,
    S_X_L    = 16'h0008,
    S_B_FET  = 16'h0010,
    S_B_ID   = 16'h0020,
    S_SD_CK  = 16'h0040,
    S_SD_L   = 16'h0080,
    S_SD_LID = 16'h0100,
    S_SD_LK  = 16'h0200,
    S_SD_RK  = 16'h0400,
    S_SD_DEC = 16'h0800,
    S_SD_END = 16'h1000,
    S_DQ_RD  = 16'h2000,
    S_SU_P   = 16'h4000,
    S_SU_PK  = 16'h8000
  } state_t;

  state_t state;
  logic   su_pid_wait;  // sift-up: parent id read in flight

  // latched command
  imh_pkg::cmd_t  cmd;
  imh_pkg::id_t   arg_id;
  imh_pkg::key_t  arg_key;

  // heap bookkeeping
  imh_pkg::id_t   hc;
  imh_pkg::id_t   lc;
  imh_pkg::pos_t  pos;
  imh_pkg::id_t   idx;
  imh_pkg::id_t   cid;
  imh_pkg::key_t  ckey;
  imh_pkg::id_t   m_id;
  imh_pkg::id_t   rid;
  imh_pkg::id_t   bid;
  imh_pkg::key_t  bkey;
  imh_pkg::pos_t  bpos;
  imh_pkg::id_t   pid;

  // pending result
  imh_pkg::status_t r_status;
  imh_pkg::id_t     r_id;
  imh_pkg::key_t    r_key;
  imh_pkg::id_t     r_pos;

  // ram ports
  logic          slot_we, key_we, map_we;
  imh_pkg::id_t  slot_waddr, key_waddr, map_waddr;
  imh_pkg::id_t  slot_wdata, map_wdata;
  imh_pkg::key_t key_wdata;
  imh_pkg::id_t  slot_raddr, key_raddr, map_raddr;
  imh_pkg::id_t  slot_rdata, map_rdata;
  imh_pkg::key_t key_rdata;

  imh_pkg::pos_t child_l, child_r, hc_w;
  logic          l_out, r_in, full, id_ok, par_gt, rsp_load;
  imh_pkg::id_t  hc_inc, lc_inc;

  assign hc_w    = {1'b0, hc};
  assign child_l = {pos[imh_pkg::POS_W-2:0], 1'b0};
  assign child_r = child_l + imh_pkg::POS_W'(1);
  assign l_out   = child_l > hc_w;
  assign r_in    = child_r <= hc_w;
  assign full    = (lc >= imh_pkg::ID_W'(imh_pkg::CAPACITY)) ||
                   (hc >= imh_pkg::ID_W'(imh_pkg::CAPACITY));
  assign id_ok   = (arg_id != '0) && (arg_id <= lc);
  assign par_gt  = key_rdata > ckey;
  assign hc_inc  = hc + imh_pkg::ID_W'(1);
  assign lc_inc  = lc + imh_pkg::ID_W'(1);

  // result register loads in the response step once it is free
  assign rsp_load = (state == S_SD_END) &&
                    !(cmd == imh_pkg::CMD_BUILD && idx > imh_pkg::ID_W'(1)) &&
                    (!rsp.valid || rsp.ready);

  imh_ram #(.WIDTH(imh_pkg::ID_W), .DEPTH(imh_pkg::DEPTH)) u_slots (
    .clk, .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );
  imh_ram #(.WIDTH(imh_pkg::KEY_BITS), .DEPTH(imh_pkg::DEPTH)) u_keys (
    .clk, .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rdata)
  );
  imh_ram #(.WIDTH(imh_pkg::ID_W), .DEPTH(imh_pkg::DEPTH)) u_map (
    .clk, .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  // ram address and write selection per sequencer step
  always_comb begin
    slot_we    = 1'b0;
    key_we     = 1'b0;
    map_we     = 1'b0;
    slot_waddr = pos[imh_pkg::ID_W-1:0];
    slot_wdata = cid;
    map_waddr  = cid;
    map_wdata  = pos[imh_pkg::ID_W-1:0];
    key_waddr  = arg_id;
    key_wdata  = arg_key;
    slot_raddr = '0;
    key_raddr  = '0;
    map_raddr  = '0;
    case (state)
      S_DISP: begin
        case (cmd)
          imh_pkg::CMD_LOAD: begin
            if (!full) begin
              key_we     = 1'b1;
              key_waddr  = lc_inc;
              slot_we    = 1'b1;
              slot_waddr = hc_inc;
              slot_wdata = lc_inc;
              map_we     = 1'b1;
              map_waddr  = lc_inc;
              map_wdata  = hc_inc;
            end
          end
          imh_pkg::CMD_EXTRACT: slot_raddr = imh_pkg::ID_W'(1);
          default: begin
            map_raddr = arg_id;
            key_raddr = arg_id;
          end
        endcase
      end
      S_X_M: begin
        slot_raddr = hc;
        key_raddr  = slot_rdata;
      end
      S_X_L: begin
        map_we    = 1'b1;
        map_waddr = m_id;
        map_wdata = '0;
        key_raddr = slot_rdata;
      end
      S_B_FET: slot_raddr = idx;
      S_B_ID:  key_raddr  = slot_rdata;
      S_SD_L: begin
        if (l_out) begin
          slot_we = 1'b1;
          map_we  = 1'b1;
        end else begin
          slot_raddr = child_l[imh_pkg::ID_W-1:0];
        end
      end
      S_SD_LID: begin
        key_raddr  = slot_rdata;
        slot_raddr = child_r[imh_pkg::ID_W-1:0];
      end
      S_SD_LK: key_raddr = slot_rdata;
      S_SD_DEC: begin
        slot_we = 1'b1;
        map_we  = 1'b1;
        if (bpos != pos) begin
          slot_wdata = bid;
          map_waddr  = bid;
        end
      end
      S_DQ_RD: begin
        key_we = (cmd == imh_pkg::CMD_DECREASE) && (map_rdata != '0) &&
                 (map_rdata <= hc) && !(arg_key > key_rdata);
      end
      S_SU_P: begin
        if (su_pid_wait) begin
          key_raddr = slot_rdata;
        end else if (pos == imh_pkg::POS_W'(1)) begin
          slot_we = 1'b1;
          map_we  = 1'b1;
        end else begin
          slot_raddr = pos[imh_pkg::ID_W:1];
        end
      end
      S_SU_PK: begin
        slot_we = 1'b1;
        map_we  = 1'b1;
        if (par_gt) begin
          slot_wdata = pid;
          map_waddr  = pid;
        end
      end
      default: ;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      su_pid_wait <= 1'b0;
      hc          <= '0;
      lc          <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !rsp_load) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd     <= imh_pkg::cmd_t'(req.command);
            arg_id  <= req.element_id;
            arg_key <= req.key_value;
            state   <= S_DISP;
          end
        end
        S_DISP: begin
          r_key <= '0;
          r_pos <= '0;
          case (cmd)
            imh_pkg::CMD_LOAD: begin
              r_id <= '0;
              if (full) begin
                r_status <= imh_pkg::ST_BAD;
              end else begin
                r_status <= imh_pkg::ST_OK;
                lc       <= lc_inc;
                hc       <= hc_inc;
              end
              state <= S_SD_END;
            end
            imh_pkg::CMD_BUILD: begin
              r_id     <= '0;
              r_status <= imh_pkg::ST_OK;
              idx      <= hc >> 1;
              if ((hc >> 1) == '0) begin
                state <= S_SD_END;
              end else begin
                state <= S_B_FET;
              end
            end
            imh_pkg::CMD_EXTRACT: begin
              r_id <= '0;
              if (hc == '0) begin
                r_status <= imh_pkg::ST_EMPTY;
                state    <= S_SD_END;
              end else begin
                r_status <= imh_pkg::ST_OK;
                state    <= S_X_M;
              end
            end
            imh_pkg::CMD_DECREASE, imh_pkg::CMD_QUERY: begin
              r_id <= arg_id;
              if (!id_ok) begin
                r_status <= imh_pkg::ST_BAD;
                state    <= S_SD_END;
              end else begin
                r_status <= imh_pkg::ST_OK;
                state    <= S_DQ_RD;
              end
            end
            default: begin
              r_id     <= '0;
              r_status <= imh_pkg::ST_OK;
              state    <= S_SD_END;
            end
          endcase
        end
        S_X_M: begin
          m_id  <= slot_rdata;
          r_id  <= slot_rdata;
          state <= S_X_L;
        end
        S_X_L: begin
          r_key <= key_rdata;
          hc    <= hc - imh_pkg::ID_W'(1);
          cid   <= slot_rdata;
          pos   <= imh_pkg::POS_W'(1);
          if (hc == imh_pkg::ID_W'(1)) begin
            state <= S_SD_END;
          end else begin
            state <= S_SD_CK;
          end
        end
        S_B_FET: state <= S_B_ID;
        S_B_ID: begin
          cid   <= slot_rdata;
          pos   <= {1'b0, idx};
          state <= S_SD_CK;
        end
        S_SD_CK: begin
          ckey  <= key_rdata;
          state <= S_SD_L;
        end
        S_SD_L: begin
          if (l_out) begin
            state <= S_SD_END;
          end else begin
            state <= S_SD_LID;
          end
        end
        S_SD_LID: begin
          bid   <= slot_rdata;
          state <= S_SD_LK;
        end
        S_SD_LK: begin
          rid <= slot_rdata;
          if (key_rdata < ckey) begin
            bkey <= key_rdata;
            bpos <= child_l;
          end else begin
            bkey <= ckey;
            bpos <= pos;
          end
          if (r_in) begin
            state <= S_SD_RK;
          end else begin
            state <= S_SD_DEC;
          end
        end
        S_SD_RK: begin
          if (key_rdata < bkey) begin
            bpos <= child_r;
            bid  <= rid;
          end
          state <= S_SD_DEC;
        end
        S_SD_DEC: begin
          if (bpos == pos) begin
            state <= S_SD_END;
          end else begin
            pos   <= bpos;
            state <= S_SD_L;
          end
        end
        S_SD_END: begin
          // also the response step for every command
          if (cmd == imh_pkg::CMD_BUILD && idx > imh_pkg::ID_W'(1)) begin
            idx   <= idx - imh_pkg::ID_W'(1);
            state <= S_B_FET;
          end else if (rsp_load) begin
            rsp.valid           <= 1'b1;
            rsp.status          <= r_status;
            rsp.result_id       <= r_id;
            rsp.result_key      <= r_key;
            rsp.result_position <= r_pos;
            rsp.live_count      <= hc;
            idx                 <= '0;
            state               <= S_IDLE;
          end
        end
        S_DQ_RD: begin
          if (cmd == imh_pkg::CMD_QUERY) begin
            r_key <= key_rdata;
            r_pos <= ((map_rdata != '0) && (map_rdata <= hc)) ? map_rdata : '0;
            state <= S_SD_END;
          end else if ((map_rdata == '0) || (map_rdata > hc)) begin
            r_status <= imh_pkg::ST_BAD;
            state    <= S_SD_END;
          end else if (arg_key > key_rdata) begin
            r_status <= imh_pkg::ST_LARGER;
            r_key    <= key_rdata;
            r_pos    <= map_rdata;
            state    <= S_SD_END;
          end else begin
            r_key <= arg_key;
            cid   <= arg_id;
            ckey  <= arg_key;
            pos   <= {1'b0, map_rdata};
            state <= S_SU_P;
          end
        end
        S_SU_P: begin
          if (su_pid_wait) begin
            pid         <= slot_rdata;
            su_pid_wait <= 1'b0;
            state       <= S_SU_PK;
          end else if (pos == imh_pkg::POS_W'(1)) begin
            r_pos <= pos[imh_pkg::ID_W-1:0];
            state <= S_SD_END;
          end else begin
            su_pid_wait <= 1'b1;
          end
        end
        S_SU_PK: begin
          if (par_gt) begin
            pos   <= pos >> 1;
            state <= S_SU_P;
          end else begin
            r_pos <= pos[imh_pkg::ID_W-1:0];
            state <= S_SD_END;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/imh_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_checker
// port-level checks on the indexed min-heap results
// ----------------------------------------------------------------------------
module imh_checker (
  input logic         clk,
  input logic         rst,
  input logic         rsp_valid,
  input logic         rsp_ready,
  input logic [1:0]   status,
  input imh_pkg::id_t result_id,
  input imh_pkg::id_t result_position,
  input imh_pkg::id_t live_count
);

  // stalled result holds its status, id and live count
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
    $stable(result_id) && $stable(live_count))
    else $error("stalled result changed");

  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> live_count <= imh_pkg::ID_W'(imh_pkg::CAPACITY))
    else $error("live count above capacity");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == imh_pkg::ST_EMPTY |->
    live_count == '0 && result_id == '0)
    else $error("empty extract with live elements");

  a_larger: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == imh_pkg::ST_LARGER |->
    result_position != '0 && result_position <= live_count)
    else $error("larger key outside heap");

endmodule

bind indexed_min_heap imh_checker u_imh_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .status          (rsp.status),
  .result_id       (rsp.result_id),
  .result_position (rsp.result_position),
  .live_count      (rsp.live_count)
);

/* sim/tb_indexed_min_heap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_min_heap
// self-checking bench: directed table then random command streams, each
// result compared with an in-bench heap predictor, random idling both sides
// ----------------------------------------------------------------------------
module tb_indexed_min_heap;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  imh_req_if req ();
  imh_rsp_if rsp ();

  indexed_min_heap i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // one result as the block reports it
  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  rid;
    logic [31:0] rkey;
    logic [8:0]  rpos;
    logic [8:0]  live;
  } heap_result_t;

  // directed row: command, id, key, and an optional typed-in result
  typedef struct {
    logic [2:0]   cmd;
    logic [8:0]   id;
    logic [31:0]  key;
    bit           fixed;
    heap_result_t res;
  } heap_row_t;

  // predictor state
  int unsigned slot_ids [0:imh_pkg::DEPTH-1];
  logic [31:0] elem_keys [0:imh_pkg::DEPTH-1];
  int unsigned elem_pos [0:imh_pkg::DEPTH-1];
  int unsigned in_heap;
  int unsigned n_loaded;

  heap_result_t pending_results [$];
  int   n_errors;
  int   cycles = 0;
  bit   done_sending;
  int   send_idle_pct, recv_idle_pct;

  task automatic report(input string what, input heap_result_t got,
                        input heap_result_t want);
    n_errors++;
    $display({"error %s: got st%0d id%0d key%0h pos%0d live%0d, ",
              "want st%0d id%0d key%0h pos%0d live%0d"},
             what, got.status, got.rid, got.rkey, got.rpos, got.live,
             want.status, want.rid, want.rkey, want.rpos, want.live);
  endtask

  function automatic void heap_reset();
    for (int i = 0; i < imh_pkg::DEPTH; i++) begin
      elem_pos[i] = i;
      slot_ids[i] = 0;
      elem_keys[i] = '0;
    end
    in_heap = 0;
    n_loaded = 0;
  endfunction

  function automatic logic [31:0] key_at(int unsigned p);
    return elem_keys[slot_ids[p]];
  endfunction

  function automatic void swap_at(int unsigned a, int unsigned b);
    int unsigned ea, eb;
    ea = slot_ids[a];
    eb = slot_ids[b];
    slot_ids[a] = eb;
    slot_ids[b] = ea;
    elem_pos[eb] = a;
    elem_pos[ea] = b;
  endfunction

  function automatic void sink_down(int unsigned p);
    int unsigned l, best;
    forever begin
      l = 2 * p;
      best = p;
      if (l <= in_heap && key_at(l) < key_at(best)) best = l;
      if (l + 1 <= in_heap && key_at(l + 1) < key_at(best)) best = l + 1;
      if (best == p) return;
      swap_at(p, best);
      p = best;
    end
  endfunction

  // works out the result of one command and updates the heap copy
  function automatic heap_result_t heap_predict(logic [2:0] cmd, logic [8:0] id,
                                                 logic [31:0] key);
    heap_result_t r;
    int unsigned m, last, p;
    bit id_ok;
    r = '0;
    id_ok = id >= 1 && id <= n_loaded;
    case (cmd)
      imh_pkg::CMD_LOAD: begin
        if (n_loaded >= imh_pkg::CAPACITY || in_heap >= imh_pkg::CAPACITY) begin
          r.status = imh_pkg::ST_BAD;
        end else begin
          n_loaded++;
          in_heap++;
          elem_keys[n_loaded] = key;
          slot_ids[in_heap] = n_loaded;
          elem_pos[n_loaded] = in_heap;
        end
      end
      imh_pkg::CMD_BUILD: begin
        for (int i = in_heap / 2; i > 0; i--) sink_down(i);
      end
      imh_pkg::CMD_EXTRACT: begin
        if (in_heap == 0) begin
          r.status = imh_pkg::ST_EMPTY;
        end else begin
          m = slot_ids[1];
          last = slot_ids[in_heap];
          r.rid = 9'(m);
          r.rkey = elem_keys[m];
          slot_ids[1] = last;
          elem_pos[last] = 1;
          elem_pos[m] = 0;
          in_heap--;
          if (in_heap > 0) sink_down(1);
        end
      end
      imh_pkg::CMD_DECREASE: begin
        r.rid = id;
        if (!id_ok || elem_pos[id] == 0 || elem_pos[id] > in_heap) begin
          r.status = imh_pkg::ST_BAD;
        end else if (key > elem_keys[id]) begin
          r.status = imh_pkg::ST_LARGER;
          r.rkey = elem_keys[id];
          r.rpos = 9'(elem_pos[id]);
        end else begin
          elem_keys[id] = key;
          r.rkey = key;
          p = elem_pos[id];
          while (p > 1 && key_at(p / 2) > key_at(p)) begin
            swap_at(p, p / 2);
            p = p / 2;
          end
          r.rpos = 9'(p);
        end
      end
      imh_pkg::CMD_QUERY: begin
        r.rid = id;
        if (!id_ok) begin
          r.status = imh_pkg::ST_BAD;
        end else begin
          p = elem_pos[id];
          r.rkey = elem_keys[id];
          r.rpos = (p >= 1 && p <= in_heap) ? 9'(p) : 9'd0;
        end
      end
      default: ;
    endcase
    r.live = 9'(in_heap);
    return r;
  endfunction

  // one request transfer, with random idling before it
  task automatic send_cmd(input logic [2:0] cmd, input logic [8:0] id,
                          input logic [31:0] key, input bit fixed,
                          input heap_result_t typed);
    heap_result_t want;
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req.valid <= 1'b1;
    req.command <= cmd;
    req.element_id <= id;
    req.key_value <= key;
    do @(posedge clk); while (!req.ready);
    want = heap_predict(cmd, id, key);
    if (fixed && want != typed) report("table row disagrees with predictor", typed, want);
    pending_results.push_back(want);
  endtask

  // receiver: random stall, compare each transfer with the oldest expectation
  always @(posedge clk) begin
    heap_result_t got;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.result_id, rsp.result_key, rsp.result_position,
                rsp.live_count};
        if (pending_results.size() == 0) report("unexpected result", got, '0);
        else begin
          if (got != pending_results[0]) report("result", got, pending_results[0]);
          void'(pending_results.pop_front());
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 900000) begin
      $display("indexed_min_heap: mismatch");
      $finish;
    end
  end

  function automatic heap_result_t res(logic [1:0] s, logic [8:0] i, logic [31:0] k,
                                       logic [8:0] p, logic [8:0] l);
    return '{s, i, k, p, l};
  endfunction

  // random key: often small to force ties, else extremes or full-range
  function automatic logic [31:0] rand_key();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return $urandom;
      2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom_range(1000);
    endcase
  endfunction

  initial begin
    heap_row_t rows [$];
    heap_result_t z;
    logic [8:0] id;
    logic [31:0] k;
    int n, phase_items;
    z = '0;
    n_errors = 0;
    send_idle_pct = 34;
    recv_idle_pct = 72;
    req.valid = 1'b0;
    req.command = '0;
    req.element_id = '0;
    req.key_value = '0;
    heap_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: results read off by hand where obvious
    rows = '{
      '{imh_pkg::CMD_EXTRACT, 9'd0, 32'h0, 1, res(imh_pkg::ST_EMPTY, 0, 0, 0, 0)},
      '{imh_pkg::CMD_QUERY, 9'd1, 32'h0, 1, res(imh_pkg::ST_BAD, 1, 0, 0, 0)},
      '{imh_pkg::CMD_DECREASE, 9'd0, 32'h0, 1, res(imh_pkg::ST_BAD, 0, 0, 0, 0)},
      '{imh_pkg::CMD_LOAD, 9'h1FF, 32'hFFFF_FFFF, 1, res(imh_pkg::ST_OK, 0, 0, 0, 1)},
      '{imh_pkg::CMD_LOAD, 9'd0, 32'h0, 1, res(imh_pkg::ST_OK, 0, 0, 0, 2)},
      '{imh_pkg::CMD_LOAD, 9'd0, 32'h5, 1, res(imh_pkg::ST_OK, 0, 0, 0, 3)},
      '{imh_pkg::CMD_LOAD, 9'd0, 32'h5, 0, z},
      '{imh_pkg::CMD_LOAD, 9'd0, 32'hAAAA_5555, 0, z},
      '{3'd5, 9'h1FF, 32'hFFFF_FFFF, 1, res(imh_pkg::ST_OK, 0, 0, 0, 5)},
      '{3'd7, 9'd3, 32'h1, 1, res(imh_pkg::ST_OK, 0, 0, 0, 5)},
      '{imh_pkg::CMD_BUILD, 9'd0, 32'h0, 1, res(imh_pkg::ST_OK, 0, 0, 0, 5)},
      '{imh_pkg::CMD_QUERY, 9'd2, 32'h0, 0, z},
      '{imh_pkg::CMD_QUERY, 9'd6, 32'h0, 1, res(imh_pkg::ST_BAD, 6, 0, 0, 5)},
      '{imh_pkg::CMD_QUERY, 9'h100, 32'h0, 1, res(imh_pkg::ST_BAD, 256, 0, 0, 5)},
      '{imh_pkg::CMD_DECREASE, 9'd3, 32'h9, 0, z},
      '{imh_pkg::CMD_DECREASE, 9'd1, 32'h0, 0, z},
      '{imh_pkg::CMD_DECREASE, 9'd4, 32'h5, 0, z},
      '{imh_pkg::CMD_EXTRACT, 9'd0, 32'h0, 0, z},
      '{imh_pkg::CMD_QUERY, 9'd2, 32'h0, 0, z},
      '{imh_pkg::CMD_DECREASE, 9'd2, 32'h0, 0, z},
      '{imh_pkg::CMD_LOAD, 9'd0, 32'h1, 0, z},
      '{imh_pkg::CMD_EXTRACT, 9'd0, 32'h0, 0, z},
      '{3'd6, 9'h0AA, 32'h5555_AAAA, 0, z}
    };
    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].id, rows[i].key, rows[i].fixed,
                               rows[i].res);

    // random: fill, build, then mixed decrease / extract / query with noise
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 72 : 0;
      recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 34 : 0;
      phase_items = 0;
      while (phase_items < 270) begin
        // top up with up to 8 loads per round; the capacity limit is hit in the last phase
        n = (ph == 2 && phase_items == 0) ? 260 : $urandom_range(8);
        for (int j = 0; j < n; j++) begin
          send_cmd(imh_pkg::CMD_LOAD, 9'($urandom), rand_key(), 0, z);
          phase_items++;
        end
        if ($urandom_range(3) != 0) begin
          send_cmd(imh_pkg::CMD_BUILD, 9'($urandom), $urandom, 0, z);
          phase_items++;
        end
        for (int j = 0; j < 12; j++) begin
          id = (n_loaded > 0 && $urandom_range(9) != 0) ? 9'($urandom_range(n_loaded, 1))
                                                         : 9'($urandom);
          k = $urandom_range(2) ? (elem_keys[id % imh_pkg::DEPTH] >> $urandom_range(8))
                                : rand_key();
          case ($urandom_range(9))
            0, 1, 2: send_cmd(imh_pkg::CMD_EXTRACT, 9'($urandom), $urandom, 0, z);
            3, 4, 5, 6: send_cmd(imh_pkg::CMD_DECREASE, id, k, 0, z);
            7, 8: send_cmd(imh_pkg::CMD_QUERY, id, $urandom, 0, z);
            default: send_cmd(3'($urandom_range(7, 5)), 9'($urandom), $urandom, 0, z);
          endcase
          phase_items++;
        end
      end
    end
    req.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("indexed_min_heap: match");
    end else begin
      $display("indexed_min_heap: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/imh_pkg.sv
hw/rtl/imh_if.sv
hw/rtl/imh_ram.sv
hw/rtl/indexed_min_heap.sv
hw/rtl/imh_checker.sv
sim/tb_indexed_min_heap.sv
